@@ hw/rtl/lr_pkg.sv @@
// ----------------------------------------------------------------------------
// lr_pkg
// Shared widths, command and result types, and colour decoding for the
// line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int COORD_BITS = 10;
  localparam int ERR_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [ERR_BITS-1:0] err_t;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  localparam logic [2:0] COLOUR_WHITE      = 3'd0;
  localparam logic [2:0] COLOUR_RED        = 3'd1;
  localparam logic [2:0] COLOUR_GREEN      = 3'd2;
  localparam logic [2:0] COLOUR_BLUE       = 3'd3;
  localparam logic [2:0] COLOUR_RED_GREEN  = 3'd4;
  localparam logic [2:0] COLOUR_RED_BLUE   = 3'd5;
  localparam logic [2:0] COLOUR_GREEN_BLUE = 3'd6;

  typedef struct packed {
    logic       is_load;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     major_end;
    coord_t     major_delta;
    coord_t     minor_delta;
    logic       x_is_major;
    logic       x_step_down;
    logic       y_step_down;
    logic [2:0] colour;
  } cmd_t;

  typedef struct packed {
    logic   pixel_valid;
    coord_t pixel_x;
    coord_t pixel_y;
    logic   red_on;
    logic   green_on;
    logic   blue_on;
    logic   last_pixel;
  } res_t;

  // bit 0 red, bit 1 green, bit 2 blue
  function automatic logic [2:0] colour_mask(input logic [2:0] code);
    logic [2:0] m;
    case (code)
      COLOUR_WHITE:      m = 3'b111;
      COLOUR_RED:        m = 3'b001;
      COLOUR_GREEN:      m = 3'b010;
      COLOUR_BLUE:       m = 3'b100;
      COLOUR_RED_GREEN:  m = 3'b011;
      COLOUR_RED_BLUE:   m = 3'b101;
      COLOUR_GREEN_BLUE: m = 3'b110;
      default:           m = 3'b000;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/lr_front.sv @@
// ----------------------------------------------------------------------------
// lr_front
// Request intake: classifies load and step requests and works out the
// line setup (deltas, directions, major axis) for loads.
// ----------------------------------------------------------------------------
module lr_front
  import lr_pkg::*;
(
  input  logic       push,
  input  logic       q_full,
  input  logic       mode,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  input  logic [2:0] colour_code,
  output logic       q_wr,
  output cmd_t       q_data
);

  logic   x_down;
  logic   y_down;
  coord_t adx;
  coord_t ady;
  logic   x_major;

  always_comb begin
    x_down  = end_x < start_x;
    y_down  = end_y < start_y;
    adx     = x_down ? (start_x - end_x) : (end_x - start_x);
    ady     = y_down ? (start_y - end_y) : (end_y - start_y);
    x_major = adx >= ady;

    q_wr                = push && !q_full;
    q_data.is_load      = (mode == MODE_LOAD);
    q_data.start_x      = start_x;
    q_data.start_y      = start_y;
    q_data.major_end    = x_major ? end_x : end_y;
    q_data.major_delta  = x_major ? adx : ady;
    q_data.minor_delta  = x_major ? ady : adx;
    q_data.x_is_major   = x_major;
    q_data.x_step_down  = x_down;
    q_data.y_step_down  = y_down;
    q_data.colour       = colour_code;
  end

endmodule

@@ hw/rtl/lr_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// lr_cmd_queue
// Two-entry command queue between the intake and the stepping engine.
// ----------------------------------------------------------------------------
module lr_cmd_queue
  import lr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  cmd_t wr_data,
  output logic full,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic empty
);

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/lr_back.sv @@
// ----------------------------------------------------------------------------
// lr_back
// Stepping engine: holds the active line, advances it one pixel per step
// request and queues results in a two-entry output buffer.
// ----------------------------------------------------------------------------
module lr_back
  import lr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cmd_empty,
  input  cmd_t cmd,
  output logic cmd_pop,
  input  logic res_pop,
  output logic res_empty,
  output res_t res
);

  coord_t     cur_x;
  coord_t     cur_y;
  coord_t     major_end;
  coord_t     major_delta;
  coord_t     minor_delta;
  err_t       error_acc;
  logic       x_is_major;
  logic       x_step_down;
  logic       y_step_down;
  logic [2:0] held_colour;
  logic       line_active;

  res_t       res_mem [2];
  logic       res_wr_ptr;
  logic       res_rd_ptr;
  logic [1:0] res_count;

  logic       take;
  logic       res_push;
  logic       res_take;
  logic       minor_step;
  err_t       err_sub;
  err_t       error_acc_next;
  coord_t     x_minor;
  coord_t     y_minor;
  coord_t     cur_x_next;
  coord_t     cur_y_next;
  logic       line_done;
  logic [2:0] mask;
  res_t       res_new;

  assign take      = !cmd_empty && (res_count != 2'd2);
  assign cmd_pop   = take;
  assign res_push  = take && !cmd.is_load;
  assign res_empty = (res_count == 2'd0);
  assign res_take  = res_pop && !res_empty;
  assign res       = res_mem[res_rd_ptr];

  always_comb begin
    minor_step = error_acc > 0;
    err_sub    = minor_step ? (error_acc - err_t'({2'b00, major_delta})) : error_acc;
    error_acc_next = err_sub + err_t'({2'b00, minor_delta});

    x_minor = cur_x;
    y_minor = cur_y;
    if (minor_step) begin
      if (x_is_major) begin
        y_minor = y_step_down ? (cur_y - coord_t'(1)) : (cur_y + coord_t'(1));
      end else begin
        x_minor = x_step_down ? (cur_x - coord_t'(1)) : (cur_x + coord_t'(1));
      end
    end
    cur_x_next = x_minor;
    cur_y_next = y_minor;
    if (x_is_major) begin
      cur_x_next = x_step_down ? (x_minor - coord_t'(1)) : (x_minor + coord_t'(1));
    end else begin
      cur_y_next = y_step_down ? (y_minor - coord_t'(1)) : (y_minor + coord_t'(1));
    end
    line_done = x_is_major ? (cur_x_next == major_end) : (cur_y_next == major_end);

    mask    = colour_mask(held_colour);
    res_new = '0;
    if (line_active) begin
      res_new.pixel_valid = 1'b1;
      res_new.pixel_x     = cur_x;
      res_new.pixel_y     = cur_y;
      res_new.red_on      = mask[0];
      res_new.green_on    = mask[1];
      res_new.blue_on     = mask[2];
      res_new.last_pixel  = line_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x       <= '0;
      cur_y       <= '0;
      major_end   <= '0;
      major_delta <= '0;
      minor_delta <= '0;
      error_acc   <= '0;
      x_is_major  <= 1'b1;
      x_step_down <= 1'b0;
      y_step_down <= 1'b0;
      held_colour <= 3'd0;
      line_active <= 1'b0;
    end else if (take) begin
      if (cmd.is_load) begin
        cur_x       <= cmd.start_x;
        cur_y       <= cmd.start_y;
        major_end   <= cmd.major_end;
        major_delta <= cmd.major_delta;
        minor_delta <= cmd.minor_delta;
        error_acc   <= '0;
        x_is_major  <= cmd.x_is_major;
        x_step_down <= cmd.x_step_down;
        y_step_down <= cmd.y_step_down;
        held_colour <= cmd.colour;
        line_active <= (cmd.major_delta != '0);
      end else if (line_active) begin
        cur_x       <= cur_x_next;
        cur_y       <= cur_y_next;
        error_acc   <= error_acc_next;
        line_active <= !line_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_wr_ptr <= 1'b0;
      res_rd_ptr <= 1'b0;
      res_count  <= 2'd0;
    end else begin
      if (res_push) begin
        res_wr_ptr <= ~res_wr_ptr;
      end
      if (res_take) begin
        res_rd_ptr <= ~res_rd_ptr;
      end
      res_count <= res_count + {1'b0, res_push} - {1'b0, res_take};
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      res_mem[res_wr_ptr] <= res_new;
    end
  end

endmodule

@@ hw/rtl/line_rasterizer_core.sv @@
// ----------------------------------------------------------------------------
// line_rasterizer_core
// Bresenham line rasterizer with queue-style request and result ports.
// ----------------------------------------------------------------------------
// A request is taken every clock while full is low. A load request (mode 0)
// sets up a line and gives no result; each step request (mode 1) gives one
// result, the next pixel with its channel mask, or pixel_valid low once the
// line is finished. Requests sustain one per cycle while results are popped.
// A result reaches the result ports once the stepping engine has taken its
// request from the two-entry command queue, which it does while the output
// buffer has room; its error update then writes the result into a two-entry
// output buffer, where it stays until popped.
module line_rasterizer_core
  import lr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       mode,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y,
  input  logic [2:0] colour_code,
  output logic       empty,
  input  logic       pop,
  output logic       pixel_valid,
  output coord_t     pixel_x,
  output coord_t     pixel_y,
  output logic       red_on,
  output logic       green_on,
  output logic       blue_on,
  output logic       last_pixel
);

  logic q_wr;
  cmd_t q_wdata;
  logic q_empty;
  cmd_t q_rdata;
  logic q_rd;
  res_t res;

  lr_front u_front (
    .push        (push),
    .q_full      (full),
    .mode        (mode),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y),
    .colour_code (colour_code),
    .q_wr        (q_wr),
    .q_data      (q_wdata)
  );

  lr_cmd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr),
    .wr_data (q_wdata),
    .full    (full),
    .rd_en   (q_rd),
    .rd_data (q_rdata),
    .empty   (q_empty)
  );

  lr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (q_empty),
    .cmd       (q_rdata),
    .cmd_pop   (q_rd),
    .res_pop   (pop),
    .res_empty (empty),
    .res       (res)
  );

  assign pixel_valid = res.pixel_valid;
  assign pixel_x     = res.pixel_x;
  assign pixel_y     = res.pixel_y;
  assign red_on      = res.red_on;
  assign green_on    = res.green_on;
  assign blue_on     = res.blue_on;
  assign last_pixel  = res.last_pixel;

endmodule

@@ dv/line_rasterizer_core_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_rasterizer_core_test
// Drives load and step requests into the line rasterizer through its push/full
// port and takes pixels from its empty/pop port, with random gaps on both
// sides, one long result stall that backs the block up, and full drains mid-run and at the end.
// A scoreboard class steps its own copy of the line state for each accepted
// request and checks every popped pixel against the oldest expected one.
// ----------------------------------------------------------------------------
module line_rasterizer_core_test;
  import lr_pkg::*;

  localparam int CYCLE_LIMIT     = 250000;
  localparam int TOTAL_REQUESTS  = 720;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int TAIL_CYCLES     = 20;
  localparam int COORD_MAX       = (1 << COORD_BITS) - 1;

  typedef struct {
    logic       mode;
    coord_t     start_x;
    coord_t     start_y;
    coord_t     end_x;
    coord_t     end_y;
    logic [2:0] colour;
  } request_t;

  class pixel_scoreboard;
    coord_t     cur_x, cur_y, major_end, major_delta, minor_delta;
    err_t       err;
    logic       x_major, x_down, y_down, active;
    logic [2:0] colour;
    res_t       expected_pixels[$];
    int         mismatches, loads, steps, pixels, lines_done, idle_results;

    function new();
      cur_x = '0;
      cur_y = '0;
      major_end = '0;
      major_delta = '0;
      minor_delta = '0;
      err = '0;
      x_major = 1'b1;
      x_down = 1'b0;
      y_down = 1'b0;
      active = 1'b0;
      colour = '0;
    endfunction

    function logic [2:0] channels(logic [2:0] code);
      case (code)
        COLOUR_WHITE:      return 3'b111;
        COLOUR_RED:        return 3'b001;
        COLOUR_GREEN:      return 3'b010;
        COLOUR_BLUE:       return 3'b100;
        COLOUR_RED_GREEN:  return 3'b011;
        COLOUR_RED_BLUE:   return 3'b101;
        COLOUR_GREEN_BLUE: return 3'b110;
        default:           return 3'b000;
      endcase
    endfunction

    function coord_t step_coord(coord_t v, logic down);
      return down ? coord_t'(v - 1'b1) : coord_t'(v + 1'b1);
    endfunction

    function void note_request(request_t r);
      coord_t     adx, ady, major_now;
      logic [2:0] m;
      res_t       e;
      if (r.mode == MODE_LOAD) begin
        x_down = r.end_x < r.start_x;
        y_down = r.end_y < r.start_y;
        adx = x_down ? coord_t'(r.start_x - r.end_x) : coord_t'(r.end_x - r.start_x);
        ady = y_down ? coord_t'(r.start_y - r.end_y) : coord_t'(r.end_y - r.start_y);
        x_major = adx >= ady;
        cur_x = r.start_x;
        cur_y = r.start_y;
        if (x_major) begin
          major_end = r.end_x;
          major_delta = adx;
          minor_delta = ady;
        end else begin
          major_end = r.end_y;
          major_delta = ady;
          minor_delta = adx;
        end
        err = '0;
        colour = r.colour;
        active = major_delta != '0;
        loads++;
        return;
      end
      steps++;
      e = '0;
      if (!active) begin
        idle_results++;
      end else begin
        m = channels(colour);
        e.pixel_valid = 1'b1;
        e.pixel_x = cur_x;
        e.pixel_y = cur_y;
        e.red_on = m[0];
        e.green_on = m[1];
        e.blue_on = m[2];
        if (err > 0) begin
          if (x_major) cur_y = step_coord(cur_y, y_down);
          else cur_x = step_coord(cur_x, x_down);
          err = err - $signed({2'b00, major_delta});
        end
        err = err + $signed({2'b00, minor_delta});
        if (x_major) begin
          cur_x = step_coord(cur_x, x_down);
          major_now = cur_x;
        end else begin
          cur_y = step_coord(cur_y, y_down);
          major_now = cur_y;
        end
        if (major_now == major_end) begin
          active = 1'b0;
          e.last_pixel = 1'b1;
          lines_done++;
        end
        pixels++;
      end
      expected_pixels.push_back(e);
    endfunction

    function void check_pixel(res_t got);
      res_t want;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected pixel v=%0d x=%0d y=%0d rgb=%b%b%b last=%0d",
                   $realtime, got.pixel_valid, got.pixel_x, got.pixel_y, got.red_on,
                   got.green_on, got.blue_on, got.last_pixel);
        return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_valid !== want.pixel_valid || got.pixel_x !== want.pixel_x ||
          got.pixel_y !== want.pixel_y || got.red_on !== want.red_on ||
          got.green_on !== want.green_on || got.blue_on !== want.blue_on ||
          got.last_pixel !== want.last_pixel) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: pixel mismatch want v=%0d x=%0d y=%0d rgb=%b%b%b last=%0d",
                   $realtime, want.pixel_valid, want.pixel_x, want.pixel_y, want.red_on,
                   want.green_on, want.blue_on, want.last_pixel);
          $display("%0t: pixel mismatch got  v=%0d x=%0d y=%0d rgb=%b%b%b last=%0d",
                   $realtime, got.pixel_valid, got.pixel_x, got.pixel_y, got.red_on,
                   got.green_on, got.blue_on, got.last_pixel);
        end
      end
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  logic       mode;
  coord_t     start_x;
  coord_t     start_y;
  coord_t     end_x;
  coord_t     end_y;
  logic [2:0] colour_code;
  logic       empty;
  logic       pop;
  logic       pixel_valid;
  coord_t     pixel_x;
  coord_t     pixel_y;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic       last_pixel;

  pixel_scoreboard sb;
  int send_gap_max;
  int take_gap_max;
  bit hold_off_pending;
  int sent;
  int full_waits;

  line_rasterizer_core uut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .mode(mode),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .colour_code(colour_code),
    .empty(empty),
    .pop(pop),
    .pixel_valid(pixel_valid),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .red_on(red_on),
    .green_on(green_on),
    .blue_on(blue_on),
    .last_pixel(last_pixel)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d pixels still expected", CYCLE_LIMIT,
             sb.expected_pixels.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_request(request_t r);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    mode <= r.mode;
    start_x <= r.start_x;
    start_y <= r.start_y;
    end_x <= r.end_x;
    end_y <= r.end_y;
    colour_code <= r.colour;
    do begin
      @(posedge clk);
      if (full) full_waits++;
    end while (full);
    sb.note_request(r);
    sent++;
  endtask

  task automatic send_load(int sx, int sy, int ex, int ey, logic [2:0] c);
    request_t r;
    r.mode = MODE_LOAD;
    r.start_x = coord_t'(sx);
    r.start_y = coord_t'(sy);
    r.end_x = coord_t'(ex);
    r.end_y = coord_t'(ey);
    r.colour = c;
    send_request(r);
  endtask

  // step requests carry random junk in the unused fields
  task automatic send_steps(int n);
    request_t r;
    repeat (n) begin
      r.mode = MODE_STEP;
      r.start_x = coord_t'($urandom);
      r.start_y = coord_t'($urandom);
      r.end_x = coord_t'($urandom);
      r.end_y = coord_t'($urandom);
      r.colour = 3'($urandom);
      send_request(r);
    end
  endtask

  // random line starting within the screen; returns the number of pixels it yields if its end lands on the screen
  task automatic send_random_line(int max_delta, output int length);
    int sx, sy, dx, dy;
    sx = $urandom_range(0, COORD_MAX);
    sy = $urandom_range(0, COORD_MAX);
    dx = $urandom_range(0, max_delta);
    dy = $urandom_range(0, max_delta);
    if ($urandom_range(0, 1)) dx = -dx;
    if ($urandom_range(0, 1)) dy = -dy;
    if (sx + dx < 0 || sx + dx > COORD_MAX) dx = -dx;
    if (sy + dy < 0 || sy + dy > COORD_MAX) dy = -dy;
    length = (dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ? (dx < 0 ? -dx : dx)
                                                       : (dy < 0 ? -dy : dy);
    send_load(sx, sy, sx + dx, sy + dy, 3'($urandom_range(0, 7)));
  endtask

  task automatic wait_for_results();
    while (sb.expected_pixels.size() != 0) @(posedge clk);
  endtask

  initial begin : take_results
    int   gap;
    res_t got;
    pop <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        gap = $urandom_range(0, take_gap_max);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      got.pixel_valid = pixel_valid;
      got.pixel_x = pixel_x;
      got.pixel_y = pixel_y;
      got.red_on = red_on;
      got.green_on = green_on;
      got.blue_on = blue_on;
      got.last_pixel = last_pixel;
      sb.check_pixel(got);
      if ($urandom_range(0, 40) == 0) take_gap_max = $urandom_range(0, 1) ? 14 : 0;
    end
  end

  initial begin : drive_requests
    int  kind, length;
    bit  held, drained;
    sb = new();
    send_gap_max = 14;
    take_gap_max = 14;
    rst <= 1'b1;
    push <= 1'b0;
    mode <= MODE_LOAD;
    start_x <= '0;
    start_y <= '0;
    end_x <= '0;
    end_y <= '0;
    colour_code <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // step before any line, then a zero-length line
    send_steps(1);
    send_load(5, 5, 5, 5, COLOUR_WHITE);
    send_steps(1);
    // corner to corner both ways, replaced while still active
    send_load(0, 0, COORD_MAX, COORD_MAX, 3'd7);
    send_steps(2);
    send_load(COORD_MAX, COORD_MAX, 0, 0, COLOUR_RED);
    send_steps(2);
    send_load(COORD_MAX, 0, COORD_MAX - 3, COORD_MAX, COLOUR_GREEN);
    send_steps(2);
    // short lines run past their end
    send_load(10, 10, 13, 11, COLOUR_BLUE);
    send_steps(4);
    send_load(5, 5, 4, 9, COLOUR_RED_GREEN);
    send_steps(5);

    held = 1'b0;
    drained = 1'b0;
    while (sent < TOTAL_REQUESTS) begin
      if (!held && sent >= 250) begin
        held = 1'b1;
        hold_off_pending = 1'b1;
        send_gap_max = 0;
        send_random_line(600, length);
        send_steps(40);
      end
      if (!drained && sent >= 500) begin
        drained = 1'b1;
        push <= 1'b0;
        wait_for_results();
      end
      if ($urandom_range(0, 7) == 0) send_gap_max = $urandom_range(0, 1) ? 14 : 0;
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
        send_random_line($urandom_range(0, 7) == 0 ? 60 : 12, length);
        send_steps(length + $urandom_range(0, 1));
      end else if (kind < 88) begin
        send_random_line(300, length);
        send_steps($urandom_range(1, 8));
      end else if (kind < 94) begin
        send_load($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                  3'($urandom_range(0, 7)));
        send_steps($urandom_range(0, 3));
      end else if (kind < 97) begin
        send_random_line(0, length);
        send_steps($urandom_range(0, 2));
      end else begin
        send_steps($urandom_range(1, 3));
      end
    end

    push <= 1'b0;
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests: %0d loads, %0d steps giving %0d pixels over %0d finished lines",
             sent, sb.loads, sb.steps, sb.pixels, sb.lines_done);
    $display("%0d steps with no line, %0d cycles of back-pressure, %0d mismatches",
             sb.idle_results, full_waits, sb.mismatches);
    if (sb.mismatches == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
